[sv/gpm_pkg.sv]
// Package for the glob pattern matcher: transfer types, character codes and
// the element role decode shared by the cells and the top level. No dependencies.
package gpm_pkg;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NAME = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       last;
    } in_t;

    typedef struct packed {
        logic matched;
        logic too_long;
    } out_t;

    typedef struct packed {
        logic lit;
        logic dash;
        logic close;
        logic bound;
    } role_t;

    typedef struct packed {
        logic star;
        logic open_chr;
        logic keep;
        logic adv;
    } cell_flags_t;

    function automatic role_t role_of(input logic bound, input logic [7:0] c);
        role_t r;
        r.bound = bound;
        r.dash  = !bound && (c == CH_DASH);
        r.close = !bound && (c == CH_CLOSE);
        r.lit   = !bound && (c != CH_DASH) && (c != CH_CLOSE);
        return r;
    endfunction

endpackage

[sv/gpm_cell.sv]
// One pattern position of the matcher: character, class element role and
// class membership rows. Depends on gpm_pkg.
module gpm_cell
    import gpm_pkg::*;
#(
    parameter int N = 16
)
(
    input  logic              clk,
    input  logic              wr,
    input  logic [7:0]        wr_ch,
    input  logic              wr_bound,
    input  logic [7:0]        wr_prev,
    input  logic [N-1:0]      open_in,
    input  logic [N-1:0]      litseen_in,
    input  logic              valid,
    input  logic              act,
    input  logic [7:0]        name_ch,
    input  logic [N-1:0]      go,
    output cell_flags_t       flags,
    output logic [N-1:0]      contrib,
    output logic              land
);

    logic [7:0]   char_reg;
    logic [7:0]   prev_reg;
    logic         lit_reg;
    logic         bound_reg;
    logic [N-1:0] mrow_reg;
    logic [N-1:0] crow_reg;
    role_t        role;
    logic         elem_hit;

    assign role = role_of(wr_bound, wr_ch);

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            char_reg  <= wr_ch;
            prev_reg  <= wr_prev;
            lit_reg   <= role.lit;
            bound_reg <= role.bound;
            mrow_reg  <= role.lit ? open_in : (role.bound ? (open_in & litseen_in) : '0);
            crow_reg  <= role.close ? open_in : '0;
        end
    end

    always_comb
    begin
        flags.star     = valid && (char_reg == CH_STAR);
        flags.open_chr = valid && (char_reg == CH_OPEN);
        flags.keep     = act && flags.star;
        flags.adv      = act && valid && ((char_reg == CH_QUEST) ||
                         ((char_reg == name_ch) && !flags.star && !flags.open_chr));
        elem_hit       = valid && ((lit_reg && (name_ch == char_reg)) ||
                         (bound_reg && (prev_reg <= name_ch) && (name_ch <= char_reg)));
        contrib        = mrow_reg & {N{elem_hit}};
        land           = valid && (|(crow_reg & go));
    end

endmodule

[sv/glob_pattern_matcher.sv]
// Top level of the glob pattern matcher: a row of pattern cells, the active
// position set and the result register. Depends on gpm_pkg and gpm_cell.
//
// A pattern loads one character per transfer (cmd 0), then names stream one
// character per transfer (cmd 1), and a new transfer is taken in each cycle
// while the result register is empty or being drained. The active set advances
// over all cells in parallel per name character, and the result of a name is
// registered when its last character is taken. A dropped result never occurs:
// in_ready falls only while a result waits on out_ready.
module glob_pattern_matcher
    import gpm_pkg::*;
#(
    parameter int MAX_LEN = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int N  = MAX_LEN;
    localparam int LW = $clog2(N + 1);
    localparam int CW = $clog2(N + 2);
    localparam logic [N:0] START = {{N{1'b0}}, 1'b1};

    logic [LW-1:0] len_reg, len_next, len_eff;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_inc;
    logic          ovf_reg, ovf_next;
    logic          pat_open_reg, pat_open_next;
    logic          pend_reg, pend_next, pend_eff;
    logic [7:0]    lit_reg, lit_next;
    logic [N-1:0]  open_reg, open_next, open_eff;
    logic [N-1:0]  seen_reg, seen_next;
    logic [N:0]    act_reg, act_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_data_reg, out_data_next;

    logic          fire, do_load, do_name, room;
    role_t         role;
    logic [N-1:0]  wr_en, valid_pos, go, hit, land, star_v;
    cell_flags_t   fl [N];
    logic [N-1:0]  contrib [N];
    logic [N:0]    prop, gen, cin, actp, nxt;
    logic [N+1:0]  sum;
    logic          acc, too;

    assign fire     = in_valid && in_ready;
    assign do_load  = fire && (in_data.cmd == CMD_LOAD);
    assign do_name  = fire && (in_data.cmd == CMD_NAME);
    assign in_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign len_eff  = pat_open_reg ? len_reg : '0;
    assign pend_eff = pat_open_reg && pend_reg;
    assign open_eff = pat_open_reg ? open_reg : '0;
    assign room     = len_eff < LW'(N);
    assign role     = role_of(pend_eff, in_data.ch);

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign wr_en[g]     = do_load && room && (len_eff == LW'(g));
            assign valid_pos[g] = LW'(g) < len_reg;
            assign go[g]        = fl[g].open_chr && actp[g] && hit[g];
            assign star_v[g]    = fl[g].star;
            gpm_cell #(.N(N)) u_cell (
                .clk        (clk),
                .wr         (wr_en[g]),
                .wr_ch      (in_data.ch),
                .wr_bound   (pend_eff),
                .wr_prev    (lit_reg),
                .open_in    (open_eff),
                .litseen_in (seen_reg),
                .valid      (valid_pos[g]),
                .act        (actp[g]),
                .name_ch    (in_data.ch),
                .go         (go),
                .flags      (fl[g]),
                .contrib    (contrib[g]),
                .land       (land[g])
            );
        end
    endgenerate

    always_comb
    begin
        prop = '0;
        for (int k = 0; k < N; k++)
        begin
            prop[k] = star_v[k] && ((k + 1) < int'(len_reg));
        end
        gen  = prop & act_reg;
        sum  = {1'b0, prop} + {1'b0, gen};
        cin  = sum[N:0] ^ prop ^ gen;
        actp = act_reg | cin;

        hit = '0;
        for (int j = 0; j < N; j++)
        begin
            hit = hit | contrib[j];
        end

        nxt = '0;
        for (int j = 0; j < N; j++)
        begin
            nxt[j]   = nxt[j] | fl[j].keep;
            nxt[j+1] = nxt[j+1] | fl[j].adv | land[j];
        end

        acc = 1'b0;
        for (int k = 0; k <= N; k++)
        begin
            if (len_reg == LW'(k))
            begin
                acc = acc | nxt[k];
            end
        end
        for (int j = 0; j < N; j++)
        begin
            if (len_reg == LW'(j + 1))
            begin
                acc = acc | (star_v[j] && nxt[j]);
            end
        end

        cnt_inc = (cnt_reg <= CW'(N)) ? (cnt_reg + CW'(1)) : cnt_reg;
        too     = ovf_reg || (cnt_inc > CW'(N));
    end

    always_comb
    begin
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        pat_open_next  = pat_open_reg;
        pend_next      = pend_reg;
        lit_next       = lit_reg;
        open_next      = open_reg;
        seen_next      = seen_reg;
        act_next       = act_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (do_load)
        begin
            pat_open_next = !in_data.last;
            act_next      = START;
            cnt_next      = '0;
            ovf_next      = pat_open_reg && ovf_reg;
            len_next      = len_eff;
            pend_next     = pend_eff;
            open_next     = open_eff;
            if (room)
            begin
                len_next  = len_eff + LW'(1);
                pend_next = role.dash;
                if (role.lit)
                begin
                    lit_next  = in_data.ch;
                    seen_next = seen_reg | open_eff;
                end
                if (role.close)
                begin
                    open_next = '0;
                end
                for (int k = 0; k < N; k++)
                begin
                    if ((len_eff == LW'(k)) && (in_data.ch == CH_OPEN))
                    begin
                        open_next[k] = 1'b1;
                        seen_next[k] = 1'b0;
                    end
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (do_name)
        begin
            pat_open_next = 1'b0;
            if (in_data.last)
            begin
                act_next               = START;
                cnt_next               = '0;
                out_valid_next         = 1'b1;
                out_data_next.matched  = acc && !too;
                out_data_next.too_long = too;
            end
            else
            begin
                act_next = nxt;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            pat_open_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            open_reg      <= '0;
            act_reg       <= START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            pat_open_reg  <= pat_open_next;
            pend_reg      <= pend_next;
            open_reg      <= open_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        seen_reg     <= seen_next;
        out_data_reg <= out_data_next;
    end

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.matched && out_data.too_long))
        else $error("matched and too_long both set");

    a_act_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (do_name && in_data.last) |=> (act_reg == START) && (cnt_reg == '0))
        else $error("active set not restarted after a name");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(N))
        else $error("pattern length out of range");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LW'(N)))
        else $error("overflow without a full pattern");

endmodule

[verif/tb_glob_pattern_matcher.sv]
// Testbench for glob_pattern_matcher: loads patterns, streams names and checks
// each match result against a built-in predictor. Depends on gpm_pkg and the RTL.
`timescale 1ns / 100ps

module tb_glob_pattern_matcher;
    import gpm_pkg::*;

    localparam int MAX_LEN = 16;
    localparam logic [15:0] NO_LITERAL = 16'o77777;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    glob_pattern_matcher #(.MAX_LEN(MAX_LEN)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    logic [7:0]       pat_chars [MAX_LEN];
    int               pat_len;
    logic [MAX_LEN:0] active;
    int               name_cnt;
    logic             pat_ovf;
    logic             pat_open;

    in_t  pending_chars [$];
    out_t expected_matches [$];
    int   mismatches;
    bit   stim_done;
    bit   hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int class_target(int pos, logic [7:0] c);
        int          j;
        logic [15:0] prev;
        logic [15:0] hi;
        bit          hit;
        logic [7:0]  e;
        j = pos + 1;
        prev = NO_LITERAL;
        hit = 0;
        while (j < pat_len)
        begin
            e = pat_chars[j];
            j++;
            if (e == CH_CLOSE)
                return hit ? j : -1;
            if (e == CH_DASH)
            begin
                hi = (j < pat_len) ? {8'h00, pat_chars[j]} : 16'h0;
                j++;
                if (prev <= {8'h00, c} && {8'h00, c} <= hi)
                    hit = 1;
            end
            else
            begin
                prev = {8'h00, e};
                if (c == e)
                    hit = 1;
            end
        end
        return -1;
    endfunction

    function automatic void predict_match(in_t it);
        logic [MAX_LEN:0] nxt;
        int               k;
        logic [7:0]       p;
        bit               acc;
        bit               too;
        out_t             r;
        if (it.cmd == CMD_LOAD)
        begin
            if (!pat_open)
            begin
                pat_len = 0;
                pat_ovf = 0;
                pat_open = 1;
            end
            if (pat_len < MAX_LEN)
            begin
                pat_chars[pat_len] = it.ch;
                pat_len++;
            end
            else
                pat_ovf = 1;
            if (it.last)
                pat_open = 0;
            active = 1;
            name_cnt = 0;
            return;
        end
        pat_open = 0;
        if (name_cnt <= MAX_LEN)
            name_cnt++;
        for (int i = 0; i + 1 < pat_len; i++)
            if (active[i] && pat_chars[i] == CH_STAR)
                active[i + 1] = 1'b1;
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (!active[i])
                continue;
            p = pat_chars[i];
            if (p == CH_STAR)
                nxt[i] = 1'b1;
            else if (p == CH_QUEST)
                nxt[i + 1] = 1'b1;
            else if (p == CH_OPEN)
            begin
                k = class_target(i, it.ch);
                if (k >= 0 && k <= pat_len)
                    nxt[k] = 1'b1;
            end
            else if (p == it.ch)
                nxt[i + 1] = 1'b1;
        end
        active = nxt;
        if (!it.last)
            return;
        acc = active[pat_len];
        if (pat_len > 0 && pat_chars[pat_len - 1] == CH_STAR && active[pat_len - 1])
            acc = 1;
        too = pat_ovf || name_cnt > MAX_LEN;
        r.matched = acc && !too;
        r.too_long = too;
        expected_matches.push_back(r);
        active = 1;
        name_cnt = 0;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    int in_gap;
    int out_gap;
    bit quiet_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_match(in_data);
            if (in_gap > 0 || hold_off || pending_chars.size() == 0)
            begin
                in_valid <= 1'b0;
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= pending_chars.pop_front();
                in_gap   <= quiet_phase ? 0 : gap_len();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: matched=%0b too_long=%0b",
                                 out_data.matched, out_data.too_long);
                end
                else if (expected_matches[0] !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp matched=%0b too_long=%0b, got %0b %0b",
                                 expected_matches[0].matched,
                                 expected_matches[0].too_long,
                                 out_data.matched, out_data.too_long);
                    void'(expected_matches.pop_front());
                end
                else
                    void'(expected_matches.pop_front());
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap   <= quiet_phase ? 0 : gap_len();
            end
        end
    end

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CH_STAR;
        if (r < 18) return CH_QUEST;
        if (r < 24) return CH_OPEN;
        if (r < 30) return CH_CLOSE;
        if (r < 35) return CH_DASH;
        if (r < 45) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h64));
    endfunction

    task automatic push_string(logic cmd, string s);
        in_t it;
        for (int i = 0; i < s.len(); i++)
        begin
            it.cmd  = cmd;
            it.ch   = s[i];
            it.last = (i == s.len() - 1);
            pending_chars.push_back(it);
        end
    endtask

    task automatic push_random(logic cmd, int n);
        in_t it;
        for (int i = 0; i < n; i++)
        begin
            it.cmd  = cmd;
            it.ch   = rand_char();
            it.last = (i == n - 1);
            pending_chars.push_back(it);
        end
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || in_valid || expected_matches.size() != 0)
            @(posedge clk);
    endtask

    int total;
    int len;
    in_t it;

    initial
    begin
        rst_n = 1'b0;
        mismatches = 0;
        hold_off = 0;
        quiet_phase = 0;
        pat_len = 0;
        pat_ovf = 0;
        pat_open = 0;
        active = 1;
        name_cnt = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no pattern, zero bytes, extremes, classes, overflow
        push_string(CMD_NAME, "a");
        push_string(CMD_LOAD, "a?*");
        push_string(CMD_NAME, "ab");
        push_string(CMD_NAME, "abcd");
        push_string(CMD_LOAD, "*b");
        push_string(CMD_NAME, "b");
        push_string(CMD_NAME, "ab");
        push_string(CMD_LOAD, "[a-c]");
        push_string(CMD_NAME, "b");
        push_string(CMD_LOAD, "[-x]");
        push_string(CMD_NAME, "-");
        push_string(CMD_LOAD, "[ab");
        push_string(CMD_NAME, "a");
        push_string(CMD_LOAD, "[a-");
        push_string(CMD_NAME, "a");
        it = '{cmd: CMD_LOAD, ch: 8'h00, last: 1'b1};
        pending_chars.push_back(it);
        it = '{cmd: CMD_NAME, ch: 8'h00, last: 1'b1};
        pending_chars.push_back(it);
        it = '{cmd: CMD_LOAD, ch: 8'hFF, last: 1'b1};
        pending_chars.push_back(it);
        it = '{cmd: CMD_NAME, ch: 8'hFF, last: 1'b1};
        pending_chars.push_back(it);
        push_random(CMD_LOAD, MAX_LEN + 2);
        push_string(CMD_NAME, "ab");
        push_string(CMD_LOAD, "ab");
        push_string(CMD_NAME, "aaaaaaaaaaaaaaaaaaa");
        drain();

        quiet_phase = 1;
        push_string(CMD_LOAD, "a*");
        for (int i = 0; i < 6; i++)
            push_random(CMD_NAME, $urandom_range(1, 4));
        drain();
        quiet_phase = 0;

        total = 0;
        while (total < 360)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                drain();
                hold_off = 1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                hold_off = 0;
            end
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 19)
                                                : $urandom_range(1, 7);
            if ($urandom_range(0, 9) == 0)
                push_random(CMD_LOAD, len - 1 > 0 ? len - 1 : 1);
            else
                push_random(CMD_LOAD, len);
            total += len;
            for (int n = $urandom_range(1, 6); n > 0; n--)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 19)
                                                    : $urandom_range(1, 8);
                push_random(CMD_NAME, len);
                total += len;
            end
        end
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_matches.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
